// File: design/sccr_pkg.sv
package sccr_pkg;

    localparam int ENTRIES_DEF  = 64;
    localparam int PIN_BITS_DEF = 8;
    localparam int TAG_W        = 32;
    localparam int SLOT_W       = 6;

    localparam logic [1:0] KIND_LOOKUP  = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_FLUSH   = 2'd2;

    localparam logic [2:0] ST_HIT        = 3'd0;
    localparam logic [2:0] ST_FILLED     = 3'd1;
    localparam logic [2:0] ST_RELEASED   = 3'd2;
    localparam logic [2:0] ST_WRITEBACK  = 3'd3;
    localparam logic [2:0] ST_ALL_PINNED = 3'd4;
    localparam logic [2:0] ST_NONE       = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
        logic sweep;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_eval;
        logic need_sweep;
        logic victim;
    } sts_t;

endpackage

// File: design/sccr_ram.sv
module sccr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/sccr_ctrl.sv
module sccr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  sccr_pkg::sts_t sts,
    output sccr_pkg::cmd_t cmd,
    output logic          busy
);
    import sccr_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH, S_SWEEP} state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.last_eval)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = sts.need_sweep ? S_SWEEP : S_IDLE;
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.victim)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: design/sccr_dp.sv
module sccr_dp #(
    parameter int ENTRIES  = sccr_pkg::ENTRIES_DEF,
    parameter int PIN_BITS = sccr_pkg::PIN_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sccr_pkg::cmd_t               cmd,
    output sccr_pkg::sts_t               sts,
    input  logic [1:0]                   kind,
    input  logic [sccr_pkg::TAG_W-1:0]   sector,
    input  logic                         mark_dirty,
    output logic                         strobe,
    output logic [2:0]                   status,
    output logic [sccr_pkg::SLOT_W-1:0]  slot,
    output logic                         fill_valid,
    output logic                         writeback_valid,
    output logic [sccr_pkg::TAG_W-1:0]   writeback_sector,
    output logic                         last
);
    import sccr_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int PB = PIN_BITS;
    localparam int W  = TAG_W + PB + 2;
    localparam logic [IW-1:0] TOP = IW'(ENTRIES - 1);

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IW-1:0] i);
        logic [IW+SLOT_W-1:0] w;
        w = {{SLOT_W{1'b0}}, i};
        return w[SLOT_W-1:0];
    endfunction

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
        return (i == TOP) ? '0 : i + 1'b1;
    endfunction

    // request and scan state
    logic [1:0]       kind_reg, kind_next;
    logic [TAG_W-1:0] sector_reg, sector_next;
    logic             md_reg, md_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    ev_reg, ev_next;
    logic             rv_reg, rv_next;
    logic             iss_done_reg, iss_done_next;
    logic             hit_reg, hit_next;
    logic [IW-1:0]    hit_idx_reg, hit_idx_next;
    logic [W-1:0]     hit_word_reg, hit_word_next;
    logic             free_reg, free_next;
    logic [IW-1:0]    free_idx_reg, free_idx_next;
    logic             unp_reg, unp_next;
    logic             pend_reg, pend_next;
    logic [IW-1:0]    pend_idx_reg, pend_idx_next;
    logic [TAG_W-1:0] pend_tag_reg, pend_tag_next;
    logic [IW-1:0]    hand_reg, hand_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;

    // result word
    logic             strobe_reg, strobe_next;
    logic [2:0]       status_reg, status_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic             fill_reg, fill_next;
    logic             wb_reg, wb_next;
    logic [TAG_W-1:0] wbs_reg, wbs_next;
    logic             last_reg, last_next;

    logic          we;
    logic [IW-1:0] wa;
    logic [W-1:0]  wd;
    logic [W-1:0]  rd;

    logic             e_val;
    logic [TAG_W-1:0] q_tag;
    logic [PB-1:0]    q_pin;
    logic             q_acc;
    logic             q_dirty;
    logic             need_sweep;
    logic             victim;
    logic [PB-1:0]    h_pin;

    sccr_ram #(.WIDTH(W), .DEPTH(ENTRIES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (wa),
        .wdata (wd),
        .raddr (idx_reg),
        .rdata (rd)
    );

    assign e_val   = valid_reg[ev_reg];
    assign q_tag   = rd[W-1 -: TAG_W];
    assign q_pin   = e_val ? rd[PB+1:2] : '0;
    assign q_acc   = e_val & rd[1];
    assign q_dirty = e_val & rd[0];
    assign h_pin   = hit_word_reg[PB+1:2];

    assign need_sweep = (kind_reg == KIND_LOOKUP) && !hit_reg && !free_reg && unp_reg;
    assign victim     = cmd.sweep && rv_reg && (q_pin == '0) && !q_acc;

    assign sts.last_eval  = rv_reg && (ev_reg == TOP);
    assign sts.need_sweep = need_sweep;
    assign sts.victim     = victim;

    always_comb
    begin
        kind_next     = kind_reg;
        sector_next   = sector_reg;
        md_next       = md_reg;
        idx_next      = idx_reg;
        ev_next       = ev_reg;
        rv_next       = rv_reg;
        iss_done_next = iss_done_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_word_next = hit_word_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        unp_next      = unp_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        pend_tag_next = pend_tag_reg;
        hand_next     = hand_reg;
        valid_next    = valid_reg;
        we            = 1'b0;
        wa            = ev_reg;
        wd            = '0;
        strobe_next   = 1'b0;
        status_next   = status_reg;
        slot_next     = slot_reg;
        fill_next     = fill_reg;
        wb_next       = wb_reg;
        wbs_next      = wbs_reg;
        last_next     = last_reg;

        if (cmd.load)
        begin
            kind_next     = kind;
            sector_next   = sector;
            md_next       = mark_dirty;
            idx_next      = '0;
            rv_next       = 1'b0;
            iss_done_next = 1'b0;
            hit_next      = 1'b0;
            free_next     = 1'b0;
            unp_next      = 1'b0;
            pend_next     = 1'b0;
        end

        if (cmd.scan)
        begin
            // issue the next read
            rv_next = !iss_done_reg;
            ev_next = idx_reg;
            if (!iss_done_reg)
            begin
                idx_next = wrap_inc(idx_reg);
                if (idx_reg == TOP)
                begin
                    iss_done_next = 1'b1;
                end
            end
            // look at the entry read last cycle
            if (rv_reg)
            begin
                if (e_val && (q_tag == sector_reg) && !hit_reg)
                begin
                    hit_next      = 1'b1;
                    hit_idx_next  = ev_reg;
                    hit_word_next = rd;
                end
                if (!e_val && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = ev_reg;
                end
                if (q_pin == '0)
                begin
                    unp_next = 1'b1;
                end
                if ((kind_reg == KIND_FLUSH) && q_dirty)
                begin
                    // previous dirty entry goes out, this one waits
                    if (pend_reg)
                    begin
                        strobe_next = 1'b1;
                        status_next = ST_WRITEBACK;
                        slot_next   = to_slot(pend_idx_reg);
                        fill_next   = 1'b0;
                        wb_next     = 1'b1;
                        wbs_next    = pend_tag_reg;
                        last_next   = 1'b0;
                    end
                    pend_next     = 1'b1;
                    pend_idx_next = ev_reg;
                    pend_tag_next = q_tag;
                    we            = 1'b1;
                    wa            = ev_reg;
                    wd            = {rd[W-1:1], 1'b0};
                end
            end
        end

        if (cmd.finish)
        begin
            strobe_next = 1'b1;
            status_next = ST_NONE;
            slot_next   = '0;
            fill_next   = 1'b0;
            wb_next     = 1'b0;
            wbs_next    = '0;
            last_next   = 1'b1;
            unique case (kind_reg)
                KIND_LOOKUP:
                begin
                    if (hit_reg)
                    begin
                        we          = 1'b1;
                        wa          = hit_idx_reg;
                        wd          = {hit_word_reg[W-1 -: TAG_W],
                                       (&h_pin) ? h_pin : h_pin + 1'b1,
                                       hit_word_reg[1:0]};
                        status_next = ST_HIT;
                        slot_next   = to_slot(hit_idx_reg);
                    end
                    else if (free_reg)
                    begin
                        we                       = 1'b1;
                        wa                       = free_idx_reg;
                        wd                       = {sector_reg, PB'(1), 1'b1, 1'b0};
                        valid_next[free_idx_reg] = 1'b1;
                        status_next              = ST_FILLED;
                        slot_next                = to_slot(free_idx_reg);
                        fill_next                = 1'b1;
                    end
                    else if (unp_reg)
                    begin
                        // no result yet: sweep from the hand
                        strobe_next = 1'b0;
                        idx_next    = hand_reg;
                        rv_next     = 1'b0;
                    end
                    else
                    begin
                        status_next = ST_ALL_PINNED;
                    end
                end
                KIND_RELEASE:
                begin
                    if (hit_reg)
                    begin
                        we          = 1'b1;
                        wa          = hit_idx_reg;
                        wd          = {hit_word_reg[W-1 -: TAG_W],
                                       (h_pin == '0) ? h_pin : h_pin - 1'b1,
                                       hit_word_reg[1],
                                       hit_word_reg[0] | md_reg};
                        status_next = ST_RELEASED;
                        slot_next   = to_slot(hit_idx_reg);
                    end
                end
                KIND_FLUSH:
                begin
                    if (pend_reg)
                    begin
                        status_next = ST_WRITEBACK;
                        slot_next   = to_slot(pend_idx_reg);
                        wb_next     = 1'b1;
                        wbs_next    = pend_tag_reg;
                    end
                end
                default:
                begin
                    status_next = ST_NONE;
                end
            endcase
        end

        if (cmd.sweep)
        begin
            rv_next  = 1'b1;
            ev_next  = idx_reg;
            idx_next = wrap_inc(idx_reg);
            if (rv_reg && (q_pin == '0))
            begin
                we = 1'b1;
                wa = ev_reg;
                if (q_acc)
                begin
                    // second chance
                    wd = {rd[W-1:2], 1'b0, rd[0]};
                end
                else
                begin
                    wd          = {sector_reg, PB'(1), 1'b1, 1'b0};
                    hand_next   = wrap_inc(ev_reg);
                    strobe_next = 1'b1;
                    status_next = ST_FILLED;
                    slot_next   = to_slot(ev_reg);
                    fill_next   = 1'b1;
                    wb_next     = q_dirty;
                    wbs_next    = q_dirty ? q_tag : '0;
                    last_next   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg       <= 1'b0;
            iss_done_reg <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            unp_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            hand_reg     <= '0;
            valid_reg    <= '0;
            strobe_reg   <= 1'b0;
            idx_reg      <= '0;
            ev_reg       <= '0;
            kind_reg     <= KIND_LOOKUP;
        end
        else
        begin
            rv_reg       <= rv_next;
            iss_done_reg <= iss_done_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            unp_reg      <= unp_next;
            pend_reg     <= pend_next;
            hand_reg     <= hand_next;
            valid_reg    <= valid_next;
            strobe_reg   <= strobe_next;
            idx_reg      <= idx_next;
            ev_reg       <= ev_next;
            kind_reg     <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sector_reg   <= sector_next;
        md_reg       <= md_next;
        hit_idx_reg  <= hit_idx_next;
        hit_word_reg <= hit_word_next;
        free_idx_reg <= free_idx_next;
        pend_idx_reg <= pend_idx_next;
        pend_tag_reg <= pend_tag_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        fill_reg     <= fill_next;
        wb_reg       <= wb_next;
        wbs_reg      <= wbs_next;
        last_reg     <= last_next;
    end

    assign strobe           = strobe_reg;
    assign status           = status_reg;
    assign slot             = slot_reg;
    assign fill_valid       = fill_reg;
    assign writeback_valid  = wb_reg;
    assign writeback_sector = wbs_reg;
    assign last             = last_reg;

endmodule

// File: design/sector_cache_clock_replacement_core.sv
// a command scans all tags, one entry per cycle from the metadata ram; a lookup
// miss on a full cache adds a clock sweep, one entry per cycle from the hand
// throughput: one command at a time, the next may start when busy falls
// flush results come one per dirty entry during the scan, the final one at the end
// reset: asynchronous active low, clears valid bits, hand and control; no stall
module sector_cache_clock_replacement_core #(
    parameter int ENTRIES  = sccr_pkg::ENTRIES_DEF,
    parameter int PIN_BITS = sccr_pkg::PIN_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   kind,
    input  logic [sccr_pkg::TAG_W-1:0]   sector,
    input  logic                         mark_dirty,
    output logic                         strobe,
    output logic [2:0]                   status,
    output logic [sccr_pkg::SLOT_W-1:0]  slot,
    output logic                         fill_valid,
    output logic                         writeback_valid,
    output logic [sccr_pkg::TAG_W-1:0]   writeback_sector,
    output logic                         last
);
    import sccr_pkg::*;

    // command and status between the sequencer and the datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: idle, tag scan, decision, clock sweep
    sccr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath: metadata ram, valid bits, clock hand and result word register
    sccr_dp #(
        .ENTRIES  (ENTRIES),
        .PIN_BITS (PIN_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .kind             (kind),
        .sector           (sector),
        .mark_dirty       (mark_dirty),
        .strobe           (strobe),
        .status           (status),
        .slot             (slot),
        .fill_valid       (fill_valid),
        .writeback_valid  (writeback_valid),
        .writeback_sector (writeback_sector),
        .last             (last)
    );

    // a fill always comes with a filled status
    a_fill_status: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && fill_valid) |-> (status == ST_FILLED))
        else $error("fill without filled status");

    // only flush writebacks may leave the word open
    a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> (status == ST_WRITEBACK))
        else $error("non-final result outside flush");

    // an accepted command makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but not busy");

    // no result word while idle and no command pending
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !$past(busy)) |-> !strobe)
        else $error("result while idle");

endmodule
